// ===== design/mclk_pkg.sv =====
// ----------------------------------------------------------------------------
// mclk_pkg
// Shared types, register indexes and the letter code tables of the keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mclk_pkg;

  localparam int unsigned LETTER_COUNT = 26;

  localparam logic [7:0] CFG_DOT_TICKS    = 8'd0;
  localparam logic [7:0] CFG_DASH_TICKS   = 8'd1;
  localparam logic [7:0] CFG_GAP_TICKS    = 8'd2;
  localparam logic [7:0] CFG_PAUSE_TICKS  = 8'd3;

  localparam logic MODE_LETTER = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ELEM  = 4'b0010,
    PH_GAP   = 4'b0100,
    PH_PAUSE = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       mode;
    logic       in_range;
    logic [3:0] pattern;
    logic [2:0] len;
  } entry_t;

  function automatic logic [2:0] sym_len(input logic [4:0] letter);
    logic [2:0] r;
    case (letter)
      5'd0:  r = 3'd2;  5'd1:  r = 3'd4;  5'd2:  r = 3'd4;  5'd3:  r = 3'd3;
      5'd4:  r = 3'd1;  5'd5:  r = 3'd4;  5'd6:  r = 3'd3;  5'd7:  r = 3'd4;
      5'd8:  r = 3'd2;  5'd9:  r = 3'd4;  5'd10: r = 3'd3;  5'd11: r = 3'd4;
      5'd12: r = 3'd2;  5'd13: r = 3'd2;  5'd14: r = 3'd3;  5'd15: r = 3'd4;
      5'd16: r = 3'd4;  5'd17: r = 3'd3;  5'd18: r = 3'd3;  5'd19: r = 3'd1;
      5'd20: r = 3'd3;  5'd21: r = 3'd4;  5'd22: r = 3'd3;  5'd23: r = 3'd4;
      5'd24: r = 3'd4;  5'd25: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sym_bits(input logic [4:0] letter);
    logic [3:0] r;
    case (letter)
      5'd0:  r = 4'd2;  5'd1:  r = 4'd1;  5'd2:  r = 4'd5;  5'd3:  r = 4'd1;
      5'd4:  r = 4'd0;  5'd5:  r = 4'd4;  5'd6:  r = 4'd3;  5'd7:  r = 4'd0;
      5'd8:  r = 4'd0;  5'd9:  r = 4'd14; 5'd10: r = 4'd5;  5'd11: r = 4'd2;
      5'd12: r = 4'd3;  5'd13: r = 4'd1;  5'd14: r = 4'd7;  5'd15: r = 4'd6;
      5'd16: r = 4'd11; 5'd17: r = 4'd2;  5'd18: r = 4'd0;  5'd19: r = 4'd1;
      5'd20: r = 4'd4;  5'd21: r = 4'd8;  5'd22: r = 4'd6;  5'd23: r = 4'd9;
      5'd24: r = 4'd13; 5'd25: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/mclk_front.sv =====
// ----------------------------------------------------------------------------
// mclk_front
// Takes input beats, looks up the letter code and packs a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mclk_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [4:0]        letter_i,
  output logic              push_o,
  output mclk_pkg::entry_t  entry_o,
  input  logic              full_i
);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  always_comb begin
    entry_o.mode     = mode_i;
    entry_o.in_range = (letter_i < 5'(mclk_pkg::LETTER_COUNT));
    entry_o.pattern  = mclk_pkg::sym_bits(letter_i);
    entry_o.len      = mclk_pkg::sym_len(letter_i);
  end

endmodule

`default_nettype wire

// ===== design/mclk_queue.sv =====
// ----------------------------------------------------------------------------
// mclk_queue
// Two-entry queue between the classifying front and the keying back.
// ----------------------------------------------------------------------------
`default_nettype none

module mclk_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mclk_pkg::entry_t  push_entry_i,
  output logic              full_o,
  output logic              pop_valid_o,
  output mclk_pkg::entry_t  pop_entry_o,
  input  logic              pop_ready_i
);

  mclk_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign full_o      = (count_q == 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_entry_o = mem_q[rd_ptr_q];
  assign pop         = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mclk_back.sv =====
// ----------------------------------------------------------------------------
// mclk_back
// Keying state machine, tick countdown, timing registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mclk_back #(
  parameter int unsigned TICK_COUNT_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mclk_pkg::entry_t  q_entry_i,
  output logic              q_ready_o,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              led_level_o,
  output logic              busy_res_o,
  output logic              accepted_o,
  output logic              letter_done_o
);

  localparam int unsigned CW = TICK_COUNT_BITS;
  localparam logic [16:0] CNT_MAX = 17'((64'd1 << CW) - 64'd1);

  function automatic logic [CW-1:0] load_count(input logic [7:0] v);
    logic [16:0] wide;
    logic [CW-1:0] r;
    wide = {9'd0, v};
    if (wide > CNT_MAX) begin
      r = '1;
    end else begin
      r = wide[CW-1:0];
    end
    return r;
  endfunction

  logic [7:0] dot_q, dash_q, gap_q, pause_q;

  mclk_pkg::phase_e phase_q, phase_d;
  logic [3:0]    pattern_q, pattern_d;
  logic [2:0]    left_q, left_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          led_q, led_d;

  logic out_valid_q;
  logic led_out_q, busy_out_q, acc_out_q, done_out_q;
  logic acc_d, done_d;
  logic fire;
  logic [3:0] shifted;
  logic [2:0] left_dec;

  assign q_ready_o = ~out_valid_q | ~out_stall_i;
  assign fire      = q_valid_i & q_ready_o;

  always_comb begin
    phase_d   = phase_q;
    pattern_d = pattern_q;
    left_d    = left_q;
    cnt_d     = cnt_q;
    led_d     = led_q;
    acc_d     = 1'b0;
    done_d    = 1'b0;
    shifted   = {1'b0, pattern_q[3:1]};
    left_dec  = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;
    if (q_entry_i.mode == mclk_pkg::MODE_LETTER) begin
      if (phase_q == mclk_pkg::PH_IDLE && q_entry_i.in_range) begin
        pattern_d = q_entry_i.pattern;
        left_d    = q_entry_i.len;
        phase_d   = mclk_pkg::PH_ELEM;
        led_d     = 1'b0;
        cnt_d     = load_count(q_entry_i.pattern[0] ? dash_q : dot_q);
        acc_d     = 1'b1;
      end
    end else if (phase_q != mclk_pkg::PH_IDLE) begin
      if (cnt_q > CW'(1)) begin
        cnt_d = cnt_q - CW'(1);
      end else begin
        case (phase_q)
          mclk_pkg::PH_ELEM: begin
            phase_d = mclk_pkg::PH_GAP;
            led_d   = 1'b1;
            cnt_d   = load_count(gap_q);
          end
          mclk_pkg::PH_GAP: begin
            pattern_d = shifted;
            left_d    = left_dec;
            if (left_dec != 3'd0) begin
              phase_d = mclk_pkg::PH_ELEM;
              led_d   = 1'b0;
              cnt_d   = load_count(shifted[0] ? dash_q : dot_q);
            end else begin
              phase_d = mclk_pkg::PH_PAUSE;
              cnt_d   = load_count(pause_q);
            end
          end
          mclk_pkg::PH_PAUSE: begin
            phase_d = mclk_pkg::PH_IDLE;
            cnt_d   = '0;
            done_d  = 1'b1;
          end
          default: begin
            phase_d = mclk_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= 8'd2;
      dash_q  <= 8'd8;
      gap_q   <= 8'd5;
      pause_q <= 8'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mclk_pkg::CFG_DOT_TICKS:   dot_q   <= cfg_data_i;
        mclk_pkg::CFG_DASH_TICKS:  dash_q  <= cfg_data_i;
        mclk_pkg::CFG_GAP_TICKS:   gap_q   <= cfg_data_i;
        mclk_pkg::CFG_PAUSE_TICKS: pause_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mclk_pkg::PH_IDLE;
      pattern_q   <= 4'd0;
      left_q      <= 3'd0;
      cnt_q       <= '0;
      led_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q   <= phase_d;
        pattern_q <= pattern_d;
        left_q    <= left_d;
        cnt_q     <= cnt_d;
        led_q     <= led_d;
      end
      if (q_ready_o) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      led_out_q  <= led_d;
      busy_out_q <= (phase_d != mclk_pkg::PH_IDLE);
      acc_out_q  <= acc_d;
      done_out_q <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_level_o   = led_out_q;
  assign busy_res_o    = busy_out_q;
  assign accepted_o    = acc_out_q;
  assign letter_done_o = done_out_q;

endmodule

`default_nettype wire

// ===== design/morse_code_led_keyer_unit.sv =====
// ----------------------------------------------------------------------------
// morse_code_led_keyer_unit
// Keys letters A to Z as Morse code on an active-low LED, one tick per beat.
// ----------------------------------------------------------------------------
// Each input beat is either a letter (mode 0) or one timing tick (mode 1), and
// each gives exactly one result beat with the LED level, busy flag, accepted
// flag and letter-done flag. The unit takes one beat per clock while nothing
// stalls: the front looks up the letter code, a two-entry queue decouples it
// from the keying state machine, and the result sits in an output register;
// the queue entry and the result are both registered. A letter sent
// while busy is refused. Timing registers (dot, dash, element gap, letter
// pause, index 0 to 3) are written through the cfg port, always ready, and
// should only change while the unit is idle.
`default_nettype none

module morse_code_led_keyer_unit #(
  parameter int unsigned TICK_COUNT_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [4:0] letter_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       led_level_o,
  output logic       busy_res_o,
  output logic       accepted_o,
  output logic       letter_done_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic             push;
  logic             full;
  mclk_pkg::entry_t push_entry;
  logic             pop_valid;
  logic             pop_ready;
  mclk_pkg::entry_t pop_entry;

  assign cfg_ready_o = 1'b1;

  mclk_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .letter_i   (letter_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  mclk_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  mclk_back #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (pop_valid),
    .q_entry_i     (pop_entry),
    .q_ready_o     (pop_ready),
    .cfg_valid_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .led_level_o   (led_level_o),
    .busy_res_o    (busy_res_o),
    .accepted_o    (accepted_o),
    .letter_done_o (letter_done_o)
  );

endmodule

`default_nettype wire

// ===== design/mclk_checker.sv =====
// ----------------------------------------------------------------------------
// mclk_checker
// Port-level checks on the keyer results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mclk_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic led_level_o,
  input logic busy_res_o,
  input logic accepted_o,
  input logic letter_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_accept_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> busy_res_o && !led_level_o)
    else $error("accepted letter did not start a lit element");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && letter_done_o |-> !busy_res_o && led_level_o)
    else $error("letter done while still busy");

  a_idle_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> led_level_o)
    else $error("led lit while idle");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && letter_done_o))
    else $error("accepted and done in one beat");

endmodule

bind morse_code_led_keyer_unit mclk_checker u_mclk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .led_level_o   (led_level_o),
  .busy_res_o    (busy_res_o),
  .accepted_o    (accepted_o),
  .letter_done_o (letter_done_o)
);

`default_nettype wire
